@@ sv/usb_config_descriptor_class_finder_unit_defines.svh @@
// Assertion macros for the class finder checker.
`ifndef USB_CONFIG_DESCRIPTOR_CLASS_FINDER_UNIT_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_CLASS_FINDER_UNIT_DEFINES_SVH
// Same-cycle implication, disabled during reset.
`define CDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define CDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Next-cycle implication that is checked through reset too.
`define CDF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/cdf_pkg.sv @@
// Shared types, codes and helpers of the class finder.
`timescale 1ns / 1ps
`default_nettype none
package cdf_pkg;
  localparam logic [7:0] DT_INTERFACE = 8'h04;
  localparam logic [7:0] DT_ENDPOINT  = 8'h05;
  localparam logic [7:0] IF_LEN_MIN   = 8'd9;
  localparam logic [7:0] EP_LEN_MIN   = 8'd7;
  localparam logic [7:0] CLS_HID      = 8'h03;
  localparam logic [7:0] CLS_MSC      = 8'h08;
  localparam logic [7:0] CLS_COMM     = 8'h02;
  localparam logic [7:0] SUB_ACM      = 8'h02;
  localparam logic [7:0] CLS_DATA     = 8'h0A;
  localparam logic [1:0] XFER_BULK    = 2'd2;
  localparam logic [1:0] XFER_INTR    = 2'd3;
  localparam logic [15:0] MAXP_DFLT   = 16'd64;
  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_HID  = 2'd1;
  localparam logic [1:0] BC_MSC  = 2'd2;
  localparam logic [1:0] BC_CDC  = 2'd3;
  localparam int CAP_BYTES = 7;

  // Walker to finders: one step of the byte walk.
  typedef struct packed {
    logic                   step;
    logic                   last;
    logic                   do_if;
    logic                   do_ep;
    logic                   mal;
    logic [CAP_BYTES*8-1:0] cap;   // descriptor bytes 2..8, byte 2 lowest
  } cdf_ev_t;

  typedef struct packed {
    logic [1:0]  bound_class;
    logic [7:0]  interface_number;
    logic [7:0]  comm_interface;
    logic [7:0]  hid_protocol;
    logic [3:0]  in_endpoint;
    logic [3:0]  out_endpoint;
    logic [15:0] max_packet;
    logic [7:0]  poll_interval;
    logic        walk_error;
  } cdf_res_t;

  function automatic logic [15:0] pair_max(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] m;
    m = (a < b) ? a : b;
    return (m == 16'd0) ? MAXP_DFLT : m;
  endfunction
endpackage
`default_nettype wire

@@ sv/cdf_walker.sv @@
// Descriptor walker: position, length, type and field capture.
`timescale 1ns / 1ps
`default_nettype none
module cdf_walker
  import cdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_in,
  output cdf_ev_t         ev
);
  logic [7:0] pos_r, pos_nxt, len_r, len_nxt, type_r, type_nxt;
  logic [CAP_BYTES*8-1:0] cap_r, cap_nxt, cap_w;
  logic mal_r, mal_nxt;
  logic [7:0] type_w, pos_inc;

  always_comb begin
    pos_nxt = pos_r; len_nxt = len_r; type_nxt = type_r;
    cap_nxt = cap_r; mal_nxt = mal_r;
    type_w  = (pos_r == 8'd1) ? byte_in : type_r;
    cap_w   = cap_r;
    for (int k = 0; k < CAP_BYTES; k++) begin
      if (pos_r == 8'(k + 2)) cap_w[k*8 +: 8] = byte_in;
    end
    pos_inc = pos_r + 8'd1;
    ev = '0;
    ev.step = step;
    ev.last = last_in;
    ev.cap  = cap_w;
    if (step) begin
      if (mal_r) begin
        // everything up to the final byte is dropped
      end else if (pos_r == 8'd0) begin
        if (!last_in) begin
          len_nxt = byte_in; type_nxt = 8'd0; cap_nxt = '0;
          if (byte_in == 8'd0) mal_nxt = 1'b1;
          else if (byte_in > 8'd1) pos_nxt = 8'd1;
        end
      end else begin
        type_nxt = type_w;
        cap_nxt  = cap_w;
        pos_nxt  = pos_inc;
        if (pos_inc == len_r) begin
          pos_nxt  = 8'd0;
          ev.do_if = (type_w == DT_INTERFACE) && (len_r >= IF_LEN_MIN);
          ev.do_ep = (type_w == DT_ENDPOINT) && (len_r >= EP_LEN_MIN);
        end else if (last_in) begin
          mal_nxt = 1'b1;  // overrun
        end
      end
      ev.mal = mal_nxt;
      if (last_in) begin
        pos_nxt = '0; len_nxt = '0; type_nxt = '0; cap_nxt = '0; mal_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; len_r <= '0; type_r <= '0; cap_r <= '0; mal_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; len_r <= len_nxt; type_r <= type_nxt;
      cap_r <= cap_nxt; mal_r <= mal_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sv/cdf_finders.sv @@
// HID, mass-storage and CDC-ACM finders plus result selection.
`timescale 1ns / 1ps
`default_nettype none
module cdf_finders
  import cdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cdf_ev_t   ev,
  output cdf_res_t  res
);
  // HID
  logic h_found_r, h_found_nxt, h_inif_r, h_inif_nxt;
  logic [7:0] h_curif_r, h_curif_nxt, h_curpro_r, h_curpro_nxt;
  logic [3:0] h_ep_r, h_ep_nxt;
  logic [15:0] h_maxp_r, h_maxp_nxt;
  logic [7:0] h_ival_r, h_ival_nxt, h_proto_r, h_proto_nxt, h_iface_r, h_iface_nxt;
  // MSC
  logic m_done_r, m_done_nxt, m_in_r, m_in_nxt;
  logic [7:0] m_curif_r, m_curif_nxt, m_rif_r, m_rif_nxt;
  logic [3:0] m_fin_r, m_fin_nxt, m_fout_r, m_fout_nxt, m_rin_r, m_rin_nxt, m_rout_r, m_rout_nxt;
  logic [15:0] m_min_r, m_min_nxt, m_mout_r, m_mout_nxt, m_rmax_r, m_rmax_nxt;
  // CDC
  logic c_saw_r, c_saw_nxt, c_indata_r, c_indata_nxt;
  logic [7:0] c_comm_r, c_comm_nxt, c_data_r, c_data_nxt;
  logic [3:0] c_fin_r, c_fin_nxt, c_fout_r, c_fout_nxt;
  logic [15:0] c_min_r, c_min_nxt, c_mout_r, c_mout_nxt;

  logic [7:0] if_num, if_cls, if_sub, if_pro, ep_addr, ep_attr, ep_ival;
  logic [15:0] ep_mp;
  logic [3:0] ep_num;
  logic ep_in, m_tail;

  assign if_num  = ev.cap[7:0];
  assign if_cls  = ev.cap[31:24];
  assign if_sub  = ev.cap[39:32];
  assign if_pro  = ev.cap[47:40];
  assign ep_addr = ev.cap[7:0];
  assign ep_attr = ev.cap[15:8];
  assign ep_mp   = ev.cap[31:16];
  assign ep_ival = ev.cap[39:32];
  assign ep_num  = ep_addr[3:0];
  assign ep_in   = ep_addr[7];

  always_comb begin
    h_found_nxt = h_found_r; h_inif_nxt = h_inif_r; h_curif_nxt = h_curif_r;
    h_curpro_nxt = h_curpro_r; h_ep_nxt = h_ep_r; h_maxp_nxt = h_maxp_r;
    h_ival_nxt = h_ival_r; h_proto_nxt = h_proto_r; h_iface_nxt = h_iface_r;
    m_done_nxt = m_done_r; m_in_nxt = m_in_r; m_curif_nxt = m_curif_r;
    m_fin_nxt = m_fin_r; m_fout_nxt = m_fout_r; m_min_nxt = m_min_r;
    m_mout_nxt = m_mout_r; m_rif_nxt = m_rif_r; m_rin_nxt = m_rin_r;
    m_rout_nxt = m_rout_r; m_rmax_nxt = m_rmax_r;
    c_saw_nxt = c_saw_r; c_indata_nxt = c_indata_r; c_comm_nxt = c_comm_r;
    c_data_nxt = c_data_r; c_fin_nxt = c_fin_r; c_fout_nxt = c_fout_r;
    c_min_nxt = c_min_r; c_mout_nxt = c_mout_r;

    if (ev.step && ev.do_if) begin
      if (!h_found_r) begin
        h_inif_nxt = (if_cls == CLS_HID);
        if (if_cls == CLS_HID) begin
          h_curif_nxt = if_num; h_curpro_nxt = if_pro;
        end
      end
      if (!m_done_r) begin
        if (m_in_r && m_fin_r != 4'd0 && m_fout_r != 4'd0) begin
          m_done_nxt = 1'b1; m_rif_nxt = m_curif_r; m_rin_nxt = m_fin_r;
          m_rout_nxt = m_fout_r; m_rmax_nxt = pair_max(m_min_r, m_mout_r);
        end else begin
          m_in_nxt = (if_cls == CLS_MSC); m_curif_nxt = if_num;
          m_fin_nxt = '0; m_fout_nxt = '0; m_min_nxt = '0; m_mout_nxt = '0;
        end
      end
      priority if (if_cls == CLS_COMM && if_sub == SUB_ACM) begin
        c_saw_nxt = 1'b1; c_comm_nxt = if_num; c_indata_nxt = 1'b0;
      end else if (if_cls == CLS_DATA) begin
        c_indata_nxt = 1'b1; c_data_nxt = if_num;
        c_fin_nxt = '0; c_fout_nxt = '0; c_min_nxt = '0; c_mout_nxt = '0;
      end else begin
        c_indata_nxt = 1'b0;
      end
    end

    if (ev.step && ev.do_ep) begin
      if (!h_found_r && h_inif_r && ep_in && ep_attr[1:0] == XFER_INTR) begin
        h_found_nxt = 1'b1; h_iface_nxt = h_curif_r; h_proto_nxt = h_curpro_r;
        h_ep_nxt = ep_num; h_maxp_nxt = ep_mp; h_ival_nxt = ep_ival;
      end
      if (ep_attr[1:0] == XFER_BULK) begin
        if (!m_done_r && m_in_r) begin
          if (ep_in) begin m_fin_nxt = ep_num; m_min_nxt = ep_mp; end
          else begin m_fout_nxt = ep_num; m_mout_nxt = ep_mp; end
        end
        if (c_indata_r) begin
          if (ep_in) begin c_fin_nxt = ep_num; c_min_nxt = ep_mp; end
          else begin c_fout_nxt = ep_num; c_mout_nxt = ep_mp; end
        end
      end
    end

    // result, from the state after this byte
    m_tail = !ev.mal && !m_done_nxt && m_in_nxt && m_fin_nxt != 4'd0 && m_fout_nxt != 4'd0;
    res = '0;
    priority if (h_found_nxt) begin
      res.bound_class = BC_HID; res.interface_number = h_iface_nxt;
      res.hid_protocol = h_proto_nxt; res.in_endpoint = h_ep_nxt;
      res.max_packet = h_maxp_nxt; res.poll_interval = h_ival_nxt;
    end else if (m_done_nxt) begin
      res.bound_class = BC_MSC; res.interface_number = m_rif_nxt;
      res.in_endpoint = m_rin_nxt; res.out_endpoint = m_rout_nxt;
      res.max_packet = m_rmax_nxt;
    end else if (m_tail) begin
      res.bound_class = BC_MSC; res.interface_number = m_curif_nxt;
      res.in_endpoint = m_fin_nxt; res.out_endpoint = m_fout_nxt;
      res.max_packet = pair_max(m_min_nxt, m_mout_nxt);
    end else if (!ev.mal && c_saw_nxt && c_fin_nxt != 4'd0 && c_fout_nxt != 4'd0) begin
      res.bound_class = BC_CDC; res.interface_number = c_data_nxt;
      res.comm_interface = c_comm_nxt; res.in_endpoint = c_fin_nxt;
      res.out_endpoint = c_fout_nxt; res.max_packet = pair_max(c_min_nxt, c_mout_nxt);
    end else begin
      res.bound_class = BC_NONE;
    end
    res.walk_error = ev.mal;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (ev.step && ev.last)) begin
      h_found_r <= 1'b0; h_inif_r <= 1'b0; h_curif_r <= '0; h_curpro_r <= '0;
      h_ep_r <= '0; h_maxp_r <= '0; h_ival_r <= '0; h_proto_r <= '0; h_iface_r <= '0;
      m_done_r <= 1'b0; m_in_r <= 1'b0; m_curif_r <= '0; m_fin_r <= '0; m_fout_r <= '0;
      m_min_r <= '0; m_mout_r <= '0; m_rif_r <= '0; m_rin_r <= '0; m_rout_r <= '0;
      m_rmax_r <= '0;
      c_saw_r <= 1'b0; c_indata_r <= 1'b0; c_comm_r <= '0; c_data_r <= '0;
      c_fin_r <= '0; c_fout_r <= '0; c_min_r <= '0; c_mout_r <= '0;
    end else begin
      h_found_r <= h_found_nxt; h_inif_r <= h_inif_nxt; h_curif_r <= h_curif_nxt;
      h_curpro_r <= h_curpro_nxt; h_ep_r <= h_ep_nxt; h_maxp_r <= h_maxp_nxt;
      h_ival_r <= h_ival_nxt; h_proto_r <= h_proto_nxt; h_iface_r <= h_iface_nxt;
      m_done_r <= m_done_nxt; m_in_r <= m_in_nxt; m_curif_r <= m_curif_nxt;
      m_fin_r <= m_fin_nxt; m_fout_r <= m_fout_nxt; m_min_r <= m_min_nxt;
      m_mout_r <= m_mout_nxt; m_rif_r <= m_rif_nxt; m_rin_r <= m_rin_nxt;
      m_rout_r <= m_rout_nxt; m_rmax_r <= m_rmax_nxt;
      c_saw_r <= c_saw_nxt; c_indata_r <= c_indata_nxt; c_comm_r <= c_comm_nxt;
      c_data_r <= c_data_nxt; c_fin_r <= c_fin_nxt; c_fout_r <= c_fout_nxt;
      c_min_r <= c_min_nxt; c_mout_r <= c_mout_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sv/usb_config_descriptor_class_finder_unit.sv @@
// Top level: USB configuration descriptor class finder.
//
// Input stream: one configuration-descriptor byte per transaction on
// in_tdata, in_tlast high on the final byte of the blob. Bytes go into an
// input register, and from there through the walker and the three class
// finders (HID interrupt-IN, mass-storage bulk pair, CDC-ACM) combinationally.
// Output stream: exactly one result transaction per blob, produced from the
// byte that carried in_tlast; all finder state clears right after it.
// Throughput: one byte per cycle unless a final byte is held back; the
// limit is the single pass through the walker and finder update logic.
// Path: a final byte goes from the input register through the walker and
// finders into the output register that drives out_tvalid.
// Stall: the result waits in the output register; non-final bytes keep
// flowing. A final byte waits in the input register only while an older
// result is still untaken, and in_tready then drops.
// Reset (rst_n low, synchronous): walker, finders and both registers empty.
`timescale 1ns / 1ps
`default_nettype none
module usb_config_descriptor_class_finder_unit
  import cdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // blob_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // bound_class[1:0], interface_number[9:2], comm_interface[17:10],
  // hid_protocol[25:18], in_endpoint[29:26], out_endpoint[33:30],
  // max_packet[49:34], poll_interval[57:50], walk_error[58], zero pad
  output logic [63:0]      out_tdata
);
  logic       st_v_r, st_last_r;
  logic [7:0] st_byte_r;
  logic       step;
  logic       out_v_r;
  logic [63:0] out_data_r;
  cdf_ev_t    ev;
  cdf_res_t   res;

  // a final byte only moves on when the output register can take it
  assign step      = st_v_r && (!st_last_r || !out_v_r || out_tready);
  assign in_tready = !st_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else if (in_tready) begin
      st_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      st_byte_r <= in_tdata;
      st_last_r <= in_tlast;
    end
  end

  cdf_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (st_byte_r),
    .last_in (st_last_r),
    .ev      (ev)
  );

  cdf_finders u_finders (
    .clk   (clk),
    .rst_n (rst_n),
    .ev    (ev),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step && st_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && st_last_r) begin
      out_data_r <= {5'd0, res.walk_error, res.poll_interval, res.max_packet,
                     res.out_endpoint, res.in_endpoint, res.hid_protocol,
                     res.comm_interface, res.interface_number, res.bound_class};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

@@ sv/cdf_checker.sv @@
// Port-level checker for the class finder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "usb_config_descriptor_class_finder_unit_defines.svh"
module cdf_checker
  import cdf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);
  `CDF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")
  `CDF_ASSERT_IMP(a_none_zero, out_tvalid && out_tdata[1:0] == BC_NONE, out_tdata[57:2] == 56'd0, "unbound result carries data")
  `CDF_ASSERT_IMP(a_hid_no_out, out_tvalid && out_tdata[1:0] == BC_HID, out_tdata[33:30] == 4'd0 && out_tdata[17:10] == 8'd0, "HID result with OUT endpoint or comm interface")
  `CDF_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")
  `CDF_ASSERT_RST(a_reset_ready, !rst_n, in_tready, "input not ready after reset")
endmodule

bind usb_config_descriptor_class_finder_unit cdf_checker u_cdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
